/* src/kvt_pkg.sv */
// ============================================================================
// kvt_pkg: shared types and constants of the keyed value table
// Field widths, default capacity and the request opcode.
// ============================================================================
package kvt_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

endpackage

/* src/keyed_value_table_top.sv */
// ============================================================================
// keyed_value_table_top: fixed-capacity key/value table with linear search
// Raise start with opcode, key and write_value while busy is low; the request
// is taken at that clock edge. A read returns the value stored for the key;
// a write overwrites a present key or, with room, appends a new pair at the end.
// Every request yields one result, shown on ok, read_value and used_entries
// for exactly one cycle while done is high. The receiver cannot stall.
// A request with key zero, or any request on an empty table, gives done in
// the cycle after acceptance. Otherwise one key comparator walks the
// stored keys from the oldest, one per cycle, fed by a registered RAM read:
// the walk stops at the first hit, or on a miss after all n entries, n being
// the entry count when the request was taken; done is registered from the
// final comparison.
// busy stays high during the walk; a new request can be taken in the cycle
// that done is high. Reset empties the table (entry count zero); the key and
// value RAMs are not cleared, since only entries below the count are read.
// ============================================================================
module keyed_value_table_top #(
    parameter int CAPACITY = kvt_pkg::DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  kvt_pkg::opcode_t                opcode,
    input  logic [kvt_pkg::KEY_W-1:0]       key,
    input  logic signed [kvt_pkg::VAL_W-1:0] write_value,
    output logic                            done,
    output logic                            ok,
    output logic signed [kvt_pkg::VAL_W-1:0] read_value,
    output logic [CNT_W-1:0]                used_entries
);

    import kvt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    opcode_t           op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  wval_reg, wval_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;
    logic [CNT_W-1:0]  used_reg, used_next;

    opcode_t           cur_op;
    logic [KEY_W-1:0]  cur_key;
    logic [VAL_W-1:0]  cur_wval;
    logic [CNT_W-1:0]  idx_inc;
    logic              has_room;

    logic              key_we;
    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [AW-1:0]     raddr;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;

    assign cur_op   = (state_reg == ST_IDLE) ? opcode : op_reg;
    assign cur_key  = (state_reg == ST_IDLE) ? key : key_reg;
    assign cur_wval = (state_reg == ST_IDLE) ? VAL_W'(write_value) : wval_reg;
    assign idx_inc  = CNT_W'(cmp_idx_reg) + CNT_W'(1);
    assign has_room = (count_reg < CNT_W'(CAPACITY));

    kvt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (cur_key),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    kvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (cur_wval),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmp_idx_next = cmp_idx_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        wval_next    = wval_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        rval_next    = rval_reg;
        used_next    = used_reg;
        key_we       = 1'b0;
        val_we       = 1'b0;
        val_waddr    = count_reg[AW-1:0];
        raddr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    key_next  = key;
                    wval_next = VAL_W'(write_value);
                    if (key == '0)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                        rval_next = '0;
                        used_next = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: miss without a walk
                        done_next = 1'b1;
                        rval_next = '0;
                        ok_next   = 1'b0;
                        if (cur_op == OP_WRITE && has_room)
                        begin
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                        used_next = count_next;
                    end
                    else
                    begin
                        raddr        = '0;
                        cmp_idx_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                raddr = idx_inc[AW-1:0];
                if (key_rdata == key_reg)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    used_next  = count_reg;
                    state_next = ST_IDLE;
                    if (op_reg == OP_WRITE)
                    begin
                        val_we    = 1'b1;
                        val_waddr = cmp_idx_reg;
                        rval_next = '0;
                    end
                    else
                    begin
                        rval_next = val_rdata;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    // no match: append on write if there is room
                    done_next  = 1'b1;
                    rval_next  = '0;
                    ok_next    = 1'b0;
                    state_next = ST_IDLE;
                    if (op_reg == OP_WRITE && has_room)
                    begin
                        key_we     = 1'b1;
                        val_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                    used_next = count_next;
                end
                else
                begin
                    cmp_idx_next = idx_inc[AW-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        wval_reg    <= wval_next;
        ok_reg      <= ok_next;
        rval_reg    <= rval_next;
        used_reg    <= used_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign read_value   = signed'(rval_reg);
    assign used_entries = used_reg;

endmodule

/* src/kvt_ram.sv */
// ============================================================================
// kvt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the keyed value table
// Sends read and write requests through the start/busy handshake. A local
// copy of the table predicts ok, read_value and used_entries for each taken
// request, unless a directed row pins the expected result. Every done strobe
// is checked field by field, in order, against the oldest pending expectation.
// A short directed list comes first, covering empty-table reads, key zero,
// extreme keys and values, and overwrites. Then random traffic in three pacing
// phases fills the table to capacity and keeps running on the full table.
// ============================================================================
module tb_top;

    import kvt_pkg::*;

    localparam int CAP            = DEF_CAPACITY;
    localparam int RAND_PER_PHASE = 534;

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  rv;
        logic [6:0]        used;
    } result_t;

    typedef struct packed {
        opcode_t           op;
        logic [KEY_W-1:0]  k;
        logic [VAL_W-1:0]  wv;
        logic              pinned;
        result_t           res;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    opcode_t                  opcode;
    logic [KEY_W-1:0]         key;
    logic signed [VAL_W-1:0]  write_value;
    logic                     done;
    logic                     ok;
    logic signed [VAL_W-1:0]  read_value;
    logic [6:0]               used_entries;

    logic                     pin_valid;
    result_t                  pin_res;

    logic [KEY_W-1:0]         key_tab [0:CAP-1];
    logic [VAL_W-1:0]         val_tab [0:CAP-1];
    int                       tab_count;

    result_t                  pending_q [$];
    row_t                     plan_q [$];

    int errors;
    int n_requests;
    int n_checked;
    int n_hits;
    int n_misses;
    int n_appends;
    int n_overwrites;
    int n_zero_key;
    int n_full;

    keyed_value_table_top #(.CAPACITY(CAP)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key          (key),
        .write_value  (write_value),
        .done         (done),
        .ok           (ok),
        .read_value   (read_value),
        .used_entries (used_entries)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t table_access(input opcode_t op, input logic [KEY_W-1:0] k,
                                             input logic [VAL_W-1:0] wv);
        result_t r;
        int      slot;
        int      i;
        r    = '0;
        slot = -1;
        if (k == '0)
        begin
            n_zero_key++;
        end
        else
        begin
            for (i = 0; i < tab_count; i++)
            begin
                if (slot < 0 && key_tab[i] == k)
                    slot = i;
            end
            if (op == OP_READ)
            begin
                if (slot >= 0)
                begin
                    r.ok = 1'b1;
                    r.rv = val_tab[slot];
                    n_hits++;
                end
                else
                begin
                    n_misses++;
                end
            end
            else if (slot >= 0)
            begin
                val_tab[slot] = wv;
                r.ok          = 1'b1;
                n_overwrites++;
            end
            else if (tab_count < CAP)
            begin
                key_tab[tab_count] = k;
                val_tab[tab_count] = wv;
                tab_count++;
                r.ok = 1'b1;
                n_appends++;
            end
            else
            begin
                n_full++;
            end
        end
        r.used = tab_count[6:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                got.ok   = ok;
                got.rv   = read_value;
                got.used = used_entries;
                if (pending_q.size() == 0)
                begin
                    $display("%0t: result with nothing pending: ok=%0b read_value=%h used=%0d",
                             $time, got.ok, got.rv, got.used);
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    n_checked++;
                    if (got.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0b actual %0b",
                                 $time, want.ok, got.ok);
                        errors++;
                    end
                    if (got.rv !== want.rv)
                    begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $time, want.rv, got.rv);
                        errors++;
                    end
                    if (got.used !== want.used)
                    begin
                        $display("%0t: used_entries mismatch: expected %0d actual %0d",
                                 $time, want.used, got.used);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                pred = table_access(opcode, key, write_value);
                n_requests++;
                if (pin_valid)
                    pending_q.push_back(pin_res);
                else
                    pending_q.push_back(pred);
            end
        end
    end

    task automatic add_row(input opcode_t op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] wv, input logic pinned,
                           input logic p_ok, input logic [VAL_W-1:0] p_rv,
                           input logic [6:0] p_used);
        row_t r;
        r.op       = op;
        r.k        = k;
        r.wv       = wv;
        r.pinned   = pinned;
        r.res.ok   = p_ok;
        r.res.rv   = p_rv;
        r.res.used = p_used;
        plan_q.push_back(r);
    endtask

    task automatic issue(input opcode_t op, input logic [KEY_W-1:0] k,
                         input logic [VAL_W-1:0] wv, input logic pinned, input result_t pres);
        start       <= 1'b1;
        opcode      <= op;
        key         <= k;
        write_value <= wv;
        pin_valid   <= pinned;
        pin_res     <= pres;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic take_break(input int pct);
        if (pct > 0 && $urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_request(output opcode_t op, output logic [KEY_W-1:0] k,
                                output logic [VAL_W-1:0] wv);
        int c;
        c  = $urandom_range(99);
        wv = $urandom;
        if (tab_count == 0 && c < 65)
            c = 79;
        if (c < 45)
        begin
            op = OP_READ;
            k  = key_tab[$urandom_range(tab_count - 1)];
        end
        else if (c < 65)
        begin
            op = OP_WRITE;
            k  = key_tab[$urandom_range(tab_count - 1)];
        end
        else if (c < 75)
        begin
            op = OP_READ;
            k  = $urandom;
        end
        else if (c < 79)
        begin
            op = opcode_t'($urandom_range(1));
            k  = '0;
        end
        else if (c < 84)
        begin
            op = OP_WRITE;
            k  = $urandom;
        end
        else
        begin
            op = opcode_t'($urandom_range(1));
            k  = $urandom;
        end
    endtask

    initial
    begin : stimulus
        int      ph;
        int      n;
        int      idle_pct [0:2];
        opcode_t op;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] wv;
        row_t    r;

        idle_pct[0]  = 0;
        idle_pct[1]  = 79;
        idle_pct[2]  = 11;
        errors       = 0;
        n_requests   = 0;
        n_checked    = 0;
        n_hits       = 0;
        n_misses     = 0;
        n_appends    = 0;
        n_overwrites = 0;
        n_zero_key   = 0;
        n_full       = 0;
        tab_count    = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_READ;
        key          = '0;
        write_value  = '0;
        pin_valid    = 1'b0;
        pin_res      = '0;

        add_row(OP_READ,  32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_WRITE, 32'h0000_0000, 32'h0000_0005, 1'b1, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_WRITE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 7'd1);
        add_row(OP_WRITE, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000, 7'd2);
        add_row(OP_READ,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 7'd2);
        add_row(OP_READ,  32'h0000_0001, 32'h1234_5678, 1'b1, 1'b1, 32'h8000_0000, 7'd2);
        add_row(OP_WRITE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h0000_0002, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd2);
        add_row(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 7'd2);
        add_row(OP_WRITE, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h8000_0000, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_WRITE, 32'h7FFF_FFFF, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0);
        add_row(OP_READ,  32'h7FFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            r = plan_q[i];
            issue(r.op, r.k, r.wv, r.pinned, r.res);
            take_break(30);
        end
        drain();

        for (ph = 0; ph < 3; ph++)
        begin
            for (n = 0; n < RAND_PER_PHASE; n++)
            begin
                pick_request(op, k, wv);
                issue(op, k, wv, 1'b0, '0);
                take_break(idle_pct[ph]);
            end
            drain();
        end

        start <= 1'b0;
        for (n = 0; n < 2000 && pending_q.size() != 0; n++)
            @(posedge clk);
        repeat (CAP + 8) @(posedge clk);

        if (pending_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_q.size());
            errors++;
        end

        $display("covered %0d requests: %0d read hits, %0d read misses, %0d appends, %0d overwrites",
                 n_requests, n_hits, n_misses, n_appends, n_overwrites);
        $display("rejected %0d zero-key and %0d table-full requests; %0d results checked",
                 n_zero_key, n_full, n_checked);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/kvt_pkg.sv
src/kvt_ram.sv
src/keyed_value_table_top.sv
dv/tb_top.sv
